// ===== src/pbd_pkg.sv =====
// ----------------------------------------------------------------------------
// pbd_pkg
// Shared types and constants for the PackBits scanline decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package pbd_pkg;

   localparam int UNIT_LANES_DEFAULT = 4;
   localparam int NUM_UNIT_FIELDS    = 4;
   localparam int CSR_INDEX_W        = 2;
   localparam int CSR_DATA_W         = 15;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_MODE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_BYTES = 2'd1;

   // line status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
   localparam logic [1:0] STATUS_UNDERFILL = 2'd3;

   typedef enum logic [1:0] {
      PH_HEADER,
      PH_LITERAL,
      PH_REPEAT
   } phase_type;

   typedef enum logic {
      ST_WAIT,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [7:0] src_byte;
      logic       end_of_line;
   } pbd_req_type;

   typedef struct packed {
      logic [15:0] unit_a;
      logic [15:0] unit_b;
      logic [15:0] unit_c;
      logic [15:0] unit_d;
      logic [2:0]  unit_count;
      logic        last_of_item;
      logic        line_done;
      logic [1:0]  status;
   } pbd_rsp_type;

   typedef struct packed {
      logic accept;   // process the request byte
      logic emit;     // load the next result into the output register
   } pbd_cmd_type;

   typedef struct packed {
      logic acc_result;  // the byte being accepted yields at least one result
      logic emit_final;  // the pending group is the last one of its byte
   } pbd_sts_type;

endpackage

`default_nettype wire

// ===== src/pbd_datapath.sv =====
// ----------------------------------------------------------------------------
// pbd_datapath
// Line state, run decoding, pending result group and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_datapath #(
   parameter int UNIT_LANES = pbd_pkg::UNIT_LANES_DEFAULT
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire pbd_pkg::pbd_req_type           req_data,
   output pbd_pkg::pbd_rsp_type                rsp_data,
   input  wire                                 csr_valid,
   output logic                                csr_ready,
   input  wire [pbd_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire [pbd_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  wire pbd_pkg::pbd_cmd_type           cmd,
   output pbd_pkg::pbd_sts_type                sts
);
   import pbd_pkg::*;

   localparam int LANES_EFF = (UNIT_LANES < 1) ? 1 :
                              ((UNIT_LANES > NUM_UNIT_FIELDS) ? NUM_UNIT_FIELDS : UNIT_LANES);

   // configuration
   logic        cfg_mode16_ff;
   logic [14:0] cfg_row_bytes_ff;

   // line state
   logic        line_open_ff, line_open_in;
   logic        mode16_ff,    mode16_in;
   phase_type   phase_ff,     phase_in;
   logic [7:0]  run_left_ff,  run_left_in;
   logic [14:0] units_left_ff, units_left_in;
   logic [7:0]  hold_ff,      hold_in;
   logic        hold_valid_ff, hold_valid_in;
   logic        line_error_ff, line_error_in;

   // pending result group
   logic [7:0]  emit_left_ff, emit_left_in;
   logic [15:0] emit_value_ff, emit_value_in;
   logic        pend_eol_ff;
   logic [1:0]  pend_status_ff, pend_status_in;

   pbd_rsp_type rsp_ff, rsp_in;

   // values seen by the byte, with a fresh line taking the configuration
   logic        s_mode;
   logic [14:0] s_units;
   phase_type   s_phase;
   logic [7:0]  s_run;
   logic [7:0]  s_hold;
   logic        s_hv;
   logic        s_err;

   logic [7:0]  b;
   logic        eol;
   logic [7:0]  hdr_cnt;
   logic [15:0] value;
   logic [2:0]  grp_cnt;
   logic        grp_final;
   logic [15:0] lane_val [NUM_UNIT_FIELDS];

   assign b   = req_data.src_byte;
   assign eol = req_data.end_of_line;

   assign csr_ready = 1'b1;

   always_comb begin
      s_mode  = line_open_ff ? mode16_ff : cfg_mode16_ff;
      s_units = line_open_ff ? units_left_ff :
                (cfg_mode16_ff ? {1'b0, cfg_row_bytes_ff[14:1]} : cfg_row_bytes_ff);
      s_phase = line_open_ff ? phase_ff : PH_HEADER;
      s_run   = line_open_ff ? run_left_ff : 8'd0;
      s_hold  = line_open_ff ? hold_ff : 8'd0;
      s_hv    = line_open_ff && hold_valid_ff;
      s_err   = line_open_ff && line_error_ff;
   end

   // literal: h+1, repeat: 257-h
   assign hdr_cnt = b[7] ? 8'(9'd257 - {1'b0, b}) : b + 8'd1;
   assign value   = s_mode ? {s_hold, b} : {8'd0, b};

   always_comb begin
      mode16_in     = s_mode;
      phase_in      = s_phase;
      run_left_in   = s_run;
      units_left_in = s_units;
      hold_in       = s_hold;
      hold_valid_in = s_hv;
      line_error_in = s_err;
      emit_left_in  = 8'd0;
      emit_value_in = value;

      if (!s_err) begin
         priority if (s_phase == PH_HEADER) begin
            // header on the line end skips the overflow check
            if (!eol && (15'(hdr_cnt) > s_units)) begin
               line_error_in = 1'b1;
            end else begin
               phase_in    = b[7] ? PH_REPEAT : PH_LITERAL;
               run_left_in = hdr_cnt;
            end
         end else if (s_mode && !s_hv) begin
            hold_in       = b;
            hold_valid_in = 1'b1;
         end else begin
            hold_in       = 8'd0;
            hold_valid_in = 1'b0;
            if (s_phase == PH_LITERAL) begin
               emit_left_in  = 8'd1;
               units_left_in = s_units - 15'd1;
               run_left_in   = s_run - 8'd1;
               if (s_run == 8'd1) begin
                  phase_in = PH_HEADER;
               end
            end else begin
               emit_left_in  = s_run;
               units_left_in = s_units - 15'(s_run);
               run_left_in   = 8'd0;
               phase_in      = PH_HEADER;
            end
         end
      end

      priority if (line_error_in) begin
         pend_status_in = STATUS_OVERFLOW;
      end else if ((phase_in != PH_HEADER) || hold_valid_in) begin
         pend_status_in = STATUS_TRUNCATED;
      end else if (units_left_in != 15'd0) begin
         pend_status_in = STATUS_UNDERFILL;
      end else begin
         pend_status_in = STATUS_OK;
      end

      line_open_in = !eol;
      if (eol) begin
         phase_in      = PH_HEADER;
         run_left_in   = 8'd0;
         hold_in       = 8'd0;
         hold_valid_in = 1'b0;
         line_error_in = 1'b0;
      end
   end

   assign sts.acc_result = (emit_left_in != 8'd0) || eol;

   // group of up to LANES_EFF equal units
   assign grp_cnt   = (emit_left_ff < 8'(LANES_EFF)) ? emit_left_ff[2:0] : 3'(LANES_EFF);
   assign grp_final = (emit_left_ff <= 8'(LANES_EFF));
   assign sts.emit_final = grp_final;

   always_comb begin
      for (int i = 0; i < NUM_UNIT_FIELDS; i++) begin
         lane_val[i] = (3'(i) < grp_cnt) ? emit_value_ff : 16'd0;
      end
      rsp_in.unit_a       = lane_val[0];
      rsp_in.unit_b       = lane_val[1];
      rsp_in.unit_c       = lane_val[2];
      rsp_in.unit_d       = lane_val[3];
      rsp_in.unit_count   = grp_cnt;
      rsp_in.last_of_item = grp_final;
      rsp_in.line_done    = grp_final && pend_eol_ff;
      rsp_in.status       = (grp_final && pend_eol_ff) ? pend_status_ff : STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_mode16_ff    <= 1'b0;
         cfg_row_bytes_ff <= 15'd0;
         line_open_ff     <= 1'b0;
         mode16_ff        <= 1'b0;
         phase_ff         <= PH_HEADER;
         run_left_ff      <= 8'd0;
         units_left_ff    <= 15'd0;
         hold_ff          <= 8'd0;
         hold_valid_ff    <= 1'b0;
         line_error_ff    <= 1'b0;
         emit_left_ff     <= 8'd0;
         pend_eol_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_UNIT_MODE) begin
               cfg_mode16_ff <= csr_wdata[0];
            end else if (csr_index == CSR_ROW_BYTES) begin
               cfg_row_bytes_ff <= csr_wdata;
            end
         end
         if (cmd.accept) begin
            line_open_ff  <= line_open_in;
            mode16_ff     <= mode16_in;
            phase_ff      <= phase_in;
            run_left_ff   <= run_left_in;
            units_left_ff <= units_left_in;
            hold_ff       <= hold_in;
            hold_valid_ff <= hold_valid_in;
            line_error_ff <= line_error_in;
            emit_left_ff  <= emit_left_in;
            pend_eol_ff   <= eol;
         end else if (cmd.emit) begin
            emit_left_ff  <= emit_left_ff - 8'(grp_cnt);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         emit_value_ff  <= emit_value_in;
         pend_status_ff <= pend_status_in;
      end
      if (cmd.emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

   a_hold_only_16: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (mode16_ff && line_open_ff))
      else $error("high byte held outside a 16-bit line");

   a_error_parks: assert property (@(posedge clock) disable iff (reset)
      line_error_ff |-> (phase_ff == PH_HEADER && run_left_ff == 8'd0))
      else $error("run state active after overflow");

   a_eol_closes: assert property (@(posedge clock) disable iff (reset)
      !(pend_eol_ff && line_open_ff))
      else $error("line still open after its last byte");

endmodule

`default_nettype wire

// ===== src/pbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// pbd_ctrl
// Sequencer: takes one request byte, then drains its result groups.
// ----------------------------------------------------------------------------
`default_nettype none

module pbd_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output pbd_pkg::pbd_cmd_type      cmd,
   input  wire pbd_pkg::pbd_sts_type sts
);
   import pbd_pkg::*;

   ctrl_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_WAIT: begin
            if (req_valid && sts.acc_result) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free && sts.emit_final) begin
               state_in = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      cmd.accept = 1'b0;
      cmd.emit   = 1'b0;
      unique case (state_ff)
         ST_WAIT: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
         end
         default: ;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.accept && cmd.emit))
      else $error("accept and emit in one cycle");

   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && sts.acc_result) |=> (state_ff == ST_EMIT))
      else $error("request with results did not start emitting");

   a_last_group: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.emit_final) |=> (state_ff == ST_WAIT && rsp_valid))
      else $error("last group did not return to wait");

endmodule

`default_nettype wire

// ===== src/packbits_line_decoder.sv =====
// ----------------------------------------------------------------------------
// packbits_line_decoder
// PackBits scanline decoder, 8-bit or big-endian 16-bit units.
// ----------------------------------------------------------------------------
// One compressed byte per request. A byte that yields results is taken,
// then its results are drained before the next byte is taken:
// a literal unit gives one result, a repeat run of n units gives
// ceil(n / lanes) results (up to 33 at four lanes), and a line end with no
// units gives one status-only result. The single output register is
// loaded one result group per cycle while rsp_ready lets it drain.
// The mode and row size are sampled on the first byte of each line.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_line_decoder #(
   parameter int UNIT_LANES = pbd_pkg::UNIT_LANES_DEFAULT
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             req_valid,
   output logic                            req_ready,
   input  wire pbd_pkg::pbd_req_type       req_data,
   output logic                            rsp_valid,
   input  wire                             rsp_ready,
   output pbd_pkg::pbd_rsp_type            rsp_data,
   input  wire                             csr_valid,
   output logic                            csr_ready,
   input  wire [pbd_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [pbd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import pbd_pkg::*;

   pbd_cmd_type cmd;
   pbd_sts_type sts;

   pbd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   pbd_datapath #(
      .UNIT_LANES (UNIT_LANES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule

`default_nettype wire

// ===== tb/packbits_line_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// packbits_line_decoder_tb
// Self-checking bench for the PackBits scanline decoder. A short table of
// hand-picked bytes and register writes runs first, then whole scanlines of
// random runs, some clean and some cut, overflowing or plain noise. Every
// accepted byte goes through a local decoder model and each result group is
// compared field by field in order. Both sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_line_decoder_tb;
   import pbd_pkg::*;

   localparam int UNIT_LANES      = UNIT_LANES_DEFAULT;
   localparam int LANE_GROUP      = UNIT_LANES < 1 ? 1 : (UNIT_LANES > 4 ? 4 : UNIT_LANES);
   localparam int RESET_CYCLES    = 12;
   localparam int IDLE_MAX        = 17;
   localparam int SETTLE_CYCLES   = 4;
   localparam int RX_HOLD_CYCLES  = 400;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int RANDOM_ITEMS    = 320;
   localparam int DIRECTED_LEN    = 24;

   typedef enum logic {
      ROW_BYTE,
      ROW_CSR
   } row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [CSR_INDEX_W-1:0]     idx;
      logic [CSR_DATA_W-1:0]      value;
      logic [7:0]                 src;
      logic                       eol;
      logic                       typed;   // expected status-only result given below
      logic [1:0]                 status;
   } stim_row_type;

   typedef struct packed {
      logic       typed;
      logic [1:0] status;
   } req_note_type;

   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_LEN-1] = '{
      // reset config: zero-size row, header on the line end
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h00, 1'b1, 1'b1, STATUS_TRUNCATED},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h05, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFF, 1'b1, 1'b1, STATUS_OVERFLOW},
      '{ROW_CSR,  CSR_ROW_BYTES, 15'd6,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h02, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h80, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFE, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hAA, 1'b1, 1'b0, STATUS_OK},
      '{ROW_CSR,  CSR_ROW_BYTES, 15'd32767, 8'h00, 1'b0, 1'b0, STATUS_OK},
      // longest repeat, then a long literal header on the line end
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h80, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h55, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h7F, 1'b1, 1'b1, STATUS_TRUNCATED},
      '{ROW_CSR,  CSR_UNIT_MODE, 15'd1,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_CSR,  CSR_ROW_BYTES, 15'd5,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h12, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h34, 1'b1, 1'b0, STATUS_OK},
      // line ends between the two bytes of a unit
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hAB, 1'b1, 1'b1, STATUS_TRUNCATED},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'h00, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFF, 1'b0, 1'b0, STATUS_OK},
      '{ROW_BYTE, CSR_UNIT_MODE, 15'd0,     8'hFF, 1'b1, 1'b0, STATUS_OK}
   };

   logic                    clock;
   logic                    reset;
   logic                    req_valid;
   logic                    req_ready;
   pbd_req_type             req_data;
   logic                    rsp_valid;
   logic                    rsp_ready;
   pbd_rsp_type             rsp_data;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   // decoder model state
   logic                    cfg_mode16;
   logic [14:0]             cfg_row_bytes;
   phase_type               dec_phase;
   logic [7:0]              dec_run_left;
   logic [14:0]             dec_units_left;
   logic [7:0]              dec_hi_byte;
   logic                    dec_hi_valid;
   logic [1:0]              dec_line_err;
   logic                    dec_line_open;
   logic                    dec_line_m16;

   pbd_rsp_type             decoded_q[$];
   pbd_rsp_type             expected_groups[$];
   req_note_type            req_notes[$];
   pbd_req_type             line_q[$];

   int                      mismatches = 0;
   int                      quiet_cycles = 0;
   int                      live_bytes;
   logic                    idle_on;
   logic                    rx_hold;

   packbits_line_decoder #(
      .UNIT_LANES(UNIT_LANES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------ model

   function automatic void clear_run();
      dec_phase    = PH_HEADER;
      dec_run_left = '0;
      dec_hi_byte  = '0;
      dec_hi_valid = 1'b0;
      dec_line_err = STATUS_OK;
   endfunction

   function automatic void push_group(input logic [15:0] val, input int c);
      pbd_rsp_type g;
      g            = '0;
      g.unit_a     = (c > 0) ? val : 16'h0000;
      g.unit_b     = (c > 1) ? val : 16'h0000;
      g.unit_c     = (c > 2) ? val : 16'h0000;
      g.unit_d     = (c > 3) ? val : 16'h0000;
      g.unit_count = 3'(c);
      decoded_q.push_back(g);
   endfunction

   function automatic pbd_rsp_type status_only(input logic [1:0] st);
      pbd_rsp_type g;
      g              = '0;
      g.last_of_item = 1'b1;
      g.line_done    = 1'b1;
      g.status       = st;
      return g;
   endfunction

   // fills decoded_q with the result groups caused by one byte
   function automatic void decode_byte(input pbd_req_type r);
      int          cnt;
      int          left;
      int          c;
      logic [15:0] val;
      logic [1:0]  st;
      pbd_rsp_type g;
      decoded_q.delete();
      if (!dec_line_open) begin
         dec_line_open  = 1'b1;
         dec_line_m16   = cfg_mode16;
         dec_units_left = cfg_mode16 ? (cfg_row_bytes >> 1) : cfg_row_bytes;
         clear_run();
      end
      if (dec_line_err == STATUS_OK) begin
         if (dec_phase == PH_HEADER) begin
            cnt = (r.src_byte < 8'd128) ? int'(r.src_byte) + 1 : 257 - int'(r.src_byte);
            // header on the line end skips the size check
            if (!r.end_of_line && cnt > int'(dec_units_left)) begin
               dec_line_err = STATUS_OVERFLOW;
            end else begin
               dec_phase    = (r.src_byte < 8'd128) ? PH_LITERAL : PH_REPEAT;
               dec_run_left = 8'(cnt);
            end
         end else if (dec_line_m16 && !dec_hi_valid) begin
            dec_hi_byte  = r.src_byte;
            dec_hi_valid = 1'b1;
         end else begin
            val          = dec_line_m16 ? {dec_hi_byte, r.src_byte} : {8'h00, r.src_byte};
            dec_hi_byte  = '0;
            dec_hi_valid = 1'b0;
            if (dec_phase == PH_LITERAL) begin
               push_group(val, 1);
               dec_units_left = dec_units_left - 15'd1;
               dec_run_left   = dec_run_left - 8'd1;
               if (dec_run_left == 8'd0)
                  dec_phase = PH_HEADER;
            end else begin
               left = int'(dec_run_left);
               while (left > 0) begin
                  c = (left < LANE_GROUP) ? left : LANE_GROUP;
                  push_group(val, c);
                  left -= c;
               end
               dec_units_left = dec_units_left - 15'(dec_run_left);
               dec_run_left   = '0;
               dec_phase      = PH_HEADER;
            end
         end
      end
      if (r.end_of_line) begin
         if (dec_line_err != STATUS_OK)
            st = dec_line_err;
         else if (dec_phase != PH_HEADER || dec_hi_valid)
            st = STATUS_TRUNCATED;
         else if (dec_units_left != 15'd0)
            st = STATUS_UNDERFILL;
         else
            st = STATUS_OK;
         if (decoded_q.size() == 0)
            push_group(16'h0000, 0);
         g           = decoded_q.pop_back();
         g.line_done = 1'b1;
         g.status    = st;
         decoded_q.push_back(g);
         dec_line_open = 1'b0;
         clear_run();
      end
      if (decoded_q.size() > 0) begin
         g              = decoded_q.pop_back();
         g.last_of_item = 1'b1;
         decoded_q.push_back(g);
      end
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_field(input string name, input int unsigned want,
                               input int unsigned got);
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
   endtask

   task automatic check_result(input pbd_rsp_type got);
      pbd_rsp_type want;
      if (expected_groups.size() == 0) begin
         $display("%0t: result with nothing expected, actual %h", $time, got);
         mismatches++;
         return;
      end
      want = expected_groups.pop_front();
      if (got.unit_a !== want.unit_a)       report_field("unit_a", want.unit_a, got.unit_a);
      if (got.unit_b !== want.unit_b)       report_field("unit_b", want.unit_b, got.unit_b);
      if (got.unit_c !== want.unit_c)       report_field("unit_c", want.unit_c, got.unit_c);
      if (got.unit_d !== want.unit_d)       report_field("unit_d", want.unit_d, got.unit_d);
      if (got.unit_count !== want.unit_count)
         report_field("unit_count", want.unit_count, got.unit_count);
      if (got.last_of_item !== want.last_of_item)
         report_field("last_of_item", want.last_of_item, got.last_of_item);
      if (got.line_done !== want.line_done)
         report_field("line_done", want.line_done, got.line_done);
      if (got.status !== want.status)       report_field("status", want.status, got.status);
   endtask

   req_note_type mon_note;

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (reset) begin
         cfg_mode16     = 1'b0;
         cfg_row_bytes  = '0;
         dec_line_open  = 1'b0;
         dec_line_m16   = 1'b0;
         dec_units_left = '0;
         clear_run();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_UNIT_MODE: cfg_mode16    = csr_wdata[0];
               CSR_ROW_BYTES: cfg_row_bytes = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            mon_note = req_notes.pop_front();
            decode_byte(req_data);
            if (mon_note.typed)
               expected_groups.push_back(status_only(mon_note.status));
            else
               foreach (decoded_q[k]) expected_groups.push_back(decoded_q[k]);
         end
         if (rsp_valid && rsp_ready)
            check_result(rsp_data);
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_CYCLES)
         @(posedge clock);
      $display("packbits_line_decoder_tb: done, errors");
      $finish;
   end

   // --------------------------------------------------------------- receiver

   initial begin
      int   stall;
      logic hold_done;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold && !hold_done) begin
            // long back-pressure so the decoder fills and stalls requests
            rsp_ready <= 1'b0;
            repeat (RX_HOLD_CYCLES) @(negedge clock);
            hold_done = 1'b1;
         end
         stall = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // ----------------------------------------------------------------- sender

   task automatic send_req(input pbd_req_type item, input req_note_type note);
      int gap;
      gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_notes.push_back(note);
      req_data  <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_groups.size() != 0 || req_notes.size() != 0)
         @(posedge clock);
      // a trailing byte with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic add_byte(input logic [7:0] b);
      pbd_req_type item;
      item.src_byte    = b;
      item.end_of_line = 1'b0;
      line_q.push_back(item);
   endtask

   task automatic add_unit(input logic m16);
      add_byte(8'($urandom_range(0, 255)));
      if (m16)
         add_byte(8'($urandom_range(0, 255)));
   endtask

   // one compressed scanline into line_q; mostly legal runs, some cut short,
   // some overflowing, some noise
   task automatic build_line(input logic m16, input int units);
      int          style;
      int          budget;
      int          n;
      pbd_req_type item;
      line_q.delete();
      style  = $urandom_range(0, 9);
      budget = (style == 6) ? $urandom_range(1, 6) : $urandom_range(8, 40);
      if (style <= 7) begin
         while (units > 0 && line_q.size() < budget) begin
            if (units >= 2 && $urandom_range(0, 1)) begin
               n = $urandom_range(2, units < 129 ? units : 129);
               add_byte(8'(257 - n));
               add_unit(m16);
            end else begin
               n = $urandom_range(1, ($urandom_range(0, 15) == 0) ? 128 : 6);
               if (n > units)
                  n = units;
               add_byte(8'(n - 1));
               repeat (n) add_unit(m16);
            end
            units -= n;
         end
         if (style == 7 && line_q.size() > 1)
            repeat ($urandom_range(1, line_q.size() - 1)) void'(line_q.pop_back());
         live_bytes += line_q.size();
      end else if (style == 8 && units < 129) begin
         n = $urandom_range(units + 1, 129);
         add_byte((n == 1 || (n <= 128 && $urandom_range(0, 1))) ? 8'(n - 1) : 8'(257 - n));
         live_bytes++;
         repeat ($urandom_range(0, 5)) add_byte(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 10);
         repeat (n) add_byte(8'($urandom_range(0, 255)));
         live_bytes += n;
      end
      if (line_q.size() == 0) begin
         add_byte(8'($urandom_range(0, 255)));
         live_bytes++;
      end
      item             = line_q.pop_back();
      item.end_of_line = 1'b1;
      line_q.push_back(item);
   endtask

   // ------------------------------------------------------------------- main

   initial begin
      stim_row_type  row;
      pbd_req_type   item;
      req_note_type  note;
      req_note_type  plain;
      int            phase_no;
      int            pick;
      logic          mode_cfg;
      logic [14:0]   row_cfg;

      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_UNIT_MODE;
      csr_wdata  = '0;
      idle_on    = 1'b1;
      rx_hold    = 1'b0;
      live_bytes = 0;
      plain      = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_LEN; i++) begin
         row = DIRECTED_ROWS[i];
         if (row.kind == ROW_CSR) begin
            wait_drained();
            write_csr(row.idx, row.value);
         end else begin
            item.src_byte    = row.src;
            item.end_of_line = row.eol;
            note.typed       = row.typed;
            note.status      = row.status;
            send_req(item, note);
         end
      end

      phase_no = 0;
      // the third pass carries the long receiver hold, so it always runs
      while (live_bytes < RANDOM_ITEMS || phase_no < 3) begin
         phase_no++;
         wait_drained();
         pick     = $urandom_range(0, 9);
         mode_cfg = 1'($urandom_range(0, 1));
         case (pick)
            0:       row_cfg = 15'd0;
            1:       row_cfg = 15'd32767;
            2:       row_cfg = 15'd1;
            3:       row_cfg = 15'($urandom_range(0, 32767));
            default: row_cfg = 15'($urandom_range(2, 48));
         endcase
         if (phase_no == 1) begin
            mode_cfg = 1'b1;
            row_cfg  = 15'd32767;
         end else if (phase_no == 2) begin
            mode_cfg = 1'b0;
            row_cfg  = 15'd0;
         end else if (phase_no == 3) begin
            row_cfg = 15'($urandom_range(16, 64));
         end
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_UNIT_MODE, 15'(mode_cfg));
            write_csr(CSR_ROW_BYTES, row_cfg);
         end else begin
            write_csr(CSR_ROW_BYTES, row_cfg);
            write_csr(CSR_UNIT_MODE, 15'(mode_cfg));
         end
         idle_on = ($urandom_range(0, 3) != 0);
         if (phase_no == 3) begin
            idle_on = 1'b0;
            rx_hold = 1'b1;
         end
         repeat ($urandom_range(2, 5)) begin
            build_line(mode_cfg, mode_cfg ? int'(row_cfg >> 1) : int'(row_cfg));
            foreach (line_q[k]) send_req(line_q[k], plain);
         end
      end

      wait_drained();
      if (mismatches == 0)
         $display("packbits_line_decoder_tb: done, clean");
      else
         $display("packbits_line_decoder_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire
